/* rtl/core/apdu_wildcard_table_responder_defines.svh */
`ifndef APDU_WILDCARD_TABLE_RESPONDER_DEFINES_SVH
`define APDU_WILDCARD_TABLE_RESPONDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define AWTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define AWTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/awtr_pkg.sv */
package awtr_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_PATTERN_BYTES = 64;
  localparam int DEF_ANSWER_BYTES  = 32;
  localparam int DEF_FRAME_BYTES   = 256;

  localparam logic [2:0] CMD_PAT = 3'd0;
  localparam logic [2:0] CMD_ANS = 3'd1;
  localparam logic [2:0] CMD_LEN = 3'd2;
  localparam logic [2:0] CMD_DEF = 3'd3;
  localparam logic [2:0] CMD_FRM = 3'd4;

  localparam logic [1:0] SRC_TABLE = 2'd0;
  localparam logic [1:0] SRC_DEF   = 2'd1;
  localparam logic [1:0] SRC_PLAIN = 2'd2;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_DEFLEN = 2'd1;

  localparam int         PCB_CID_BIT = 3;
  localparam logic [7:0] WILD_LEN    = 8'h01;
  localparam logic [7:0] SW1_OK      = 8'h90;
  localparam logic [7:0] SW2_OK      = 8'h00;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] entry_slot;
    logic [5:0] byte_position;
    logic [7:0] byte_value;
    logic       exact_flag;
    logic [6:0] pattern_length;
    logic [5:0] response_length;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [1:0] reply_source;
    logic [3:0] matched_entry;
  } reply_t;

  function automatic int clog2s(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* rtl/core/awtr_if.sv */
interface awtr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] entry_slot;
  logic [5:0] byte_position;
  logic [7:0] byte_value;
  logic       exact_flag;
  logic [6:0] pattern_length;
  logic [5:0] response_length;
  logic       frame_end;
  modport source(output valid, command, entry_slot, byte_position, byte_value, exact_flag,
                 pattern_length, response_length, frame_end, input ready);
  modport sink(input valid, command, entry_slot, byte_position, byte_value, exact_flag,
               pattern_length, response_length, frame_end, output ready);
endinterface

interface awtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;
  logic [1:0] reply_source;
  logic [3:0] matched_entry;
  modport source(output valid, reply_byte, reply_last, reply_source, matched_entry,
                 input ready);
  modport sink(input valid, reply_byte, reply_last, reply_source, matched_entry,
               output ready);
endinterface

interface awtr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/awtr_obuf.sv */
module awtr_obuf import awtr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  reply_t din,
  output logic   free,
  input  logic   out_ready,
  output logic   out_valid,
  output reply_t dout
);

  logic   valid_r;
  reply_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= din;
    end
  end

endmodule

/* rtl/core/awtr_engine.sv */
module awtr_engine import awtr_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int PATTERN_BYTES = DEF_PATTERN_BYTES,
  parameter int ANSWER_BYTES  = DEF_ANSWER_BYTES,
  parameter int FRAME_BYTES   = DEF_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  in_item_t   item,
  input  logic [4:0] active_entries,
  input  logic [5:0] default_length,
  output logic       busy,
  input  logic       out_free,
  output logic       push,
  output reply_t     reply
);

  localparam int FCW  = $clog2(FRAME_BYTES + 1);
  localparam int FAW  = clog2s(FRAME_BYTES);
  localparam int POSW = FCW + 1;
  localparam int SUMW = POSW + 9;
  localparam int EW   = $clog2(TABLE_ENTRIES + 1);
  localparam int ESW  = clog2s(TABLE_ENTRIES);
  localparam int PMD  = TABLE_ENTRIES * PATTERN_BYTES;
  localparam int PAW  = clog2s(PMD);
  localparam int AMD  = TABLE_ENTRIES * ANSWER_BYTES;
  localparam int AAW  = clog2s(AMD);
  localparam int DAW  = clog2s(ANSWER_BYTES);
  localparam int KW   = $clog2(ANSWER_BYTES + 3);
  localparam int JW   = $clog2(PATTERN_BYTES + 1);
  localparam logic [POSW-1:0] POS_MAX = {POSW{1'b1}};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HDR0 = 4'd1;
  localparam logic [3:0] ST_HDR1 = 4'd2;
  localparam logic [3:0] ST_HDR2 = 4'd3;
  localparam logic [3:0] ST_ENT  = 4'd4;
  localparam logic [3:0] ST_PRD  = 4'd5;
  localparam logic [3:0] ST_PEV  = 4'd6;
  localparam logic [3:0] ST_ERD  = 4'd7;
  localparam logic [3:0] ST_EPUT = 4'd8;

  logic [7:0] frame_mem [FRAME_BYTES];
  logic [8:0] pat_mem   [PMD];
  logic [7:0] ans_mem   [AMD];
  logic [7:0] def_mem   [ANSWER_BYTES];
  logic [6:0] plen_r    [TABLE_ENTRIES];
  logic [5:0] rlen_r    [TABLE_ENTRIES];

  logic [3:0]      st_r, st_nxt;
  logic [FCW-1:0]  fc_r, fc_nxt;
  logic [7:0]      pcb_r, pcb_nxt, cid_r, cid_nxt;
  logic [EW-1:0]   e_r, e_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic [POSW-1:0] pos_r, pos_nxt;
  logic [ESW-1:0]  ent_r, ent_nxt;
  logic [1:0]      src_r, src_nxt;
  logic [KW-1:0]   pay_r, pay_nxt, k_r, k_nxt;

  logic [7:0] frd_r, ard_r, drd_r;
  logic [8:0] prd_r;

  logic [FAW-1:0] frm_ra;
  logic [PAW-1:0] pat_ra;
  logic [AAW-1:0] ans_ra;
  logic [DAW-1:0] def_ra;

  logic           is_frm, frm_we;
  logic [EW-1:0]  ecount;
  logic [5:0]     dlen;
  logic           has_cid;
  logic [1:0]     hn;
  logic [ESW-1:0] e_idx;
  logic [POSW:0]  fa;
  logic [SUMW-1:0] pos_sum;
  logic           pev_fail;
  logic [JW-1:0]  j_inc;
  logic [KW-1:0]  n_bytes;
  logic           k_last;
  logic [7:0]     out_byte;

  assign busy    = (st_r != ST_IDLE);
  assign is_frm  = in_fire && (item.command == CMD_FRM);
  assign frm_we  = is_frm && (int'(fc_r) < FRAME_BYTES);
  assign ecount  = (int'(active_entries) > TABLE_ENTRIES) ? EW'(TABLE_ENTRIES)
                                                          : EW'(active_entries);
  assign dlen    = (int'(default_length) > ANSWER_BYTES) ? 6'(ANSWER_BYTES) : default_length;
  assign has_cid = pcb_r[PCB_CID_BIT];
  assign hn      = has_cid ? 2'd2 : 2'd1;
  assign e_idx   = e_r[ESW-1:0];
  assign fa      = (POSW+1)'(pos_r) + (POSW+1)'(hn);
  assign n_bytes = KW'(hn) + pay_r;
  assign k_last  = (k_r == n_bytes - KW'(1));

  // Memory read addresses
  always_comb begin
    frm_ra = '0;
    if (st_r == ST_HDR1) begin
      frm_ra = FAW'(1);
    end else if (st_r == ST_PRD) begin
      frm_ra = fa[FAW-1:0];
    end
  end
  assign pat_ra = PAW'(int'(e_idx) * PATTERN_BYTES + int'(j_r));
  assign def_ra = DAW'(k_r - KW'(hn));
  assign ans_ra = AAW'(int'(ent_r) * ANSWER_BYTES + int'(def_ra));

  always_ff @(posedge clk) begin
    if (frm_we) begin
      frame_mem[fc_r[FAW-1:0]] <= item.byte_value;
    end
    frd_r <= frame_mem[frm_ra];
  end

  always_ff @(posedge clk) begin
    if (in_fire && item.command == CMD_PAT && int'(item.entry_slot) < TABLE_ENTRIES &&
        int'(item.byte_position) < PATTERN_BYTES) begin
      pat_mem[PAW'(int'(item.entry_slot) * PATTERN_BYTES + int'(item.byte_position))] <=
        {item.exact_flag, item.byte_value};
    end
    prd_r <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk) begin
    if (in_fire && item.command == CMD_ANS && int'(item.entry_slot) < TABLE_ENTRIES &&
        int'(item.byte_position) < ANSWER_BYTES) begin
      ans_mem[AAW'(int'(item.entry_slot) * ANSWER_BYTES + int'(item.byte_position))] <=
        item.byte_value;
    end
    ard_r <= ans_mem[ans_ra];
  end

  always_ff @(posedge clk) begin
    if (in_fire && item.command == CMD_DEF && int'(item.byte_position) < ANSWER_BYTES) begin
      def_mem[DAW'(item.byte_position)] <= item.byte_value;
    end
    drd_r <= def_mem[def_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        plen_r[i] <= '0;
        rlen_r[i] <= '0;
      end
    end else if (in_fire && item.command == CMD_LEN && int'(item.entry_slot) < TABLE_ENTRIES) begin
      plen_r[ESW'(item.entry_slot)] <= (int'(item.pattern_length) > PATTERN_BYTES) ?
                                       7'(PATTERN_BYTES) : item.pattern_length;
      rlen_r[ESW'(item.entry_slot)] <= (int'(item.response_length) > ANSWER_BYTES) ?
                                       6'(ANSWER_BYTES) : item.response_length;
    end
  end

  // Pattern byte evaluation
  always_comb begin
    pos_sum  = SUMW'(pos_r) + SUMW'(1);
    if (!prd_r[8] && prd_r[7:0] == WILD_LEN) begin
      pos_sum = pos_sum + SUMW'(frd_r);
    end
    pev_fail = ((POSW+2)'(fa) + (POSW+2)'(2) >= (POSW+2)'(fc_r)) ||
               (prd_r[8] && frd_r != prd_r[7:0]);
    j_inc    = j_r + JW'(1);
  end

  always_comb begin
    if (k_r < KW'(hn)) begin
      out_byte = (k_r == '0) ? pcb_r : cid_r;
    end else begin
      case (src_r)
        SRC_TABLE: out_byte = ard_r;
        SRC_DEF:   out_byte = drd_r;
        default:   out_byte = (k_r == KW'(hn)) ? SW1_OK : SW2_OK;
      endcase
    end
  end

  assign push                = (st_r == ST_EPUT) && out_free;
  assign reply.reply_byte    = out_byte;
  assign reply.reply_last    = k_last;
  assign reply.reply_source  = src_r;
  assign reply.matched_entry = 4'(ent_r);

  always_comb begin
    st_nxt  = st_r;
    fc_nxt  = fc_r;
    pcb_nxt = pcb_r;
    cid_nxt = cid_r;
    e_nxt   = e_r;
    j_nxt   = j_r;
    pos_nxt = pos_r;
    ent_nxt = ent_r;
    src_nxt = src_r;
    pay_nxt = pay_r;
    k_nxt   = k_r;
    case (st_r)
      ST_IDLE: begin
        if (frm_we) begin
          fc_nxt = fc_r + FCW'(1);
        end
        if (is_frm && item.frame_end) begin
          st_nxt = ST_HDR0;
        end
      end
      ST_HDR0: st_nxt = ST_HDR1;
      ST_HDR1: begin
        pcb_nxt = frd_r;
        st_nxt  = ST_HDR2;
      end
      ST_HDR2: begin
        // CID that never arrived reads as zero
        cid_nxt = (int'(fc_r) >= 2) ? frd_r : 8'h00;
        e_nxt   = '0;
        st_nxt  = ST_ENT;
      end
      ST_ENT: begin
        if (e_r >= ecount) begin
          ent_nxt = '0;
          k_nxt   = '0;
          st_nxt  = ST_ERD;
          if (dlen != '0) begin
            src_nxt = SRC_DEF;
            pay_nxt = KW'(dlen);
          end else begin
            src_nxt = SRC_PLAIN;
            pay_nxt = KW'(2);
          end
        end else if (plen_r[e_idx] == '0) begin
          e_nxt = e_r + EW'(1);
        end else begin
          j_nxt   = '0;
          pos_nxt = '0;
          st_nxt  = ST_PRD;
        end
      end
      ST_PRD: st_nxt = ST_PEV;
      ST_PEV: begin
        if (pev_fail) begin
          e_nxt  = e_r + EW'(1);
          st_nxt = ST_ENT;
        end else begin
          pos_nxt = (pos_sum > SUMW'(POS_MAX)) ? POS_MAX : POSW'(pos_sum);
          j_nxt   = j_inc;
          if (int'(j_inc) == int'(plen_r[e_idx])) begin
            src_nxt = SRC_TABLE;
            ent_nxt = e_idx;
            pay_nxt = KW'(rlen_r[e_idx]);
            k_nxt   = '0;
            st_nxt  = ST_ERD;
          end else begin
            st_nxt = ST_PRD;
          end
        end
      end
      ST_ERD: st_nxt = ST_EPUT;
      ST_EPUT: begin
        if (out_free) begin
          k_nxt = k_r + KW'(1);
          if (k_last) begin
            fc_nxt = '0;
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_ERD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      fc_r <= '0;
    end else begin
      st_r <= st_nxt;
      fc_r <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pcb_r <= pcb_nxt;
    cid_r <= cid_nxt;
    e_r   <= e_nxt;
    j_r   <= j_nxt;
    pos_r <= pos_nxt;
    ent_r <= ent_nxt;
    src_r <= src_nxt;
    pay_r <= pay_nxt;
    k_r   <= k_nxt;
  end

endmodule

/* rtl/core/apdu_wildcard_table_responder.sv */
// Load commands and frame bytes are accepted one per cycle while the engine is not busy.
// After the byte with frame_end the engine reads PCB/CID, visits each entry in turn and
// closes a walk without a match, reads pattern and frame memory for each pattern byte
// tried, then for each reply byte does a memory read and fills the output register, and can stall.
// Input is held off from frame end until the last reply byte sits in the output register.
// rst_n (synchronous, active low) clears control, config and entry lengths, not the memories.
module apdu_wildcard_table_responder import awtr_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int PATTERN_BYTES = DEF_PATTERN_BYTES,
  parameter int ANSWER_BYTES  = DEF_ANSWER_BYTES,
  parameter int FRAME_BYTES   = DEF_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  awtr_in_if.sink    in_bus,
  awtr_out_if.source out_bus,
  awtr_cfg_if.sink   cfg_bus
);

  logic [4:0] active_r;
  logic [5:0] deflen_r;
  in_item_t   item;
  reply_t     reply, out_data;
  logic       busy, in_fire, out_free, push;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      deflen_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_ACTIVE: active_r <= cfg_bus.data[4:0];
        CFG_DEFLEN: deflen_r <= cfg_bus.data[5:0];
        default: ;
      endcase
    end
  end

  assign item.command         = in_bus.command;
  assign item.entry_slot      = in_bus.entry_slot;
  assign item.byte_position   = in_bus.byte_position;
  assign item.byte_value      = in_bus.byte_value;
  assign item.exact_flag      = in_bus.exact_flag;
  assign item.pattern_length  = in_bus.pattern_length;
  assign item.response_length = in_bus.response_length;
  assign item.frame_end       = in_bus.frame_end;

  assign in_bus.ready = !busy;
  assign in_fire      = in_bus.valid && !busy;

  awtr_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PATTERN_BYTES(PATTERN_BYTES),
    .ANSWER_BYTES (ANSWER_BYTES),
    .FRAME_BYTES  (FRAME_BYTES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .item          (item),
    .active_entries(active_r),
    .default_length(deflen_r),
    .busy          (busy),
    .out_free      (out_free),
    .push          (push),
    .reply         (reply)
  );

  awtr_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (reply),
    .free     (out_free),
    .out_ready(out_bus.ready),
    .out_valid(out_bus.valid),
    .dout     (out_data)
  );

  assign out_bus.reply_byte    = out_data.reply_byte;
  assign out_bus.reply_last    = out_data.reply_last;
  assign out_bus.reply_source  = out_data.reply_source;
  assign out_bus.matched_entry = out_data.matched_entry;

endmodule

/* rtl/core/awtr_checker.sv */
`include "apdu_wildcard_table_responder_defines.svh"

module awtr_checker import awtr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_command,
  input logic       in_frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [1:0] out_source,
  input logic [3:0] out_entry
);

  `AWTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "reply dropped while stalled")
  `AWTR_ASSERT_NEXT(a_frame_end_busy,
    in_valid && in_ready && in_command == CMD_FRM && in_frame_end, !in_ready,
    "input taken right after frame end")
  `AWTR_ASSERT_IMPL(a_reply_blocks_input, out_valid && !out_last, !in_ready,
    "input taken in the middle of a reply")
  `AWTR_ASSERT_IMPL(a_entry_zero, out_valid && out_source != SRC_TABLE, out_entry == 4'd0,
    "matched entry set without a table match")

endmodule

bind apdu_wildcard_table_responder awtr_checker u_awtr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .in_command  (in_bus.command),
  .in_frame_end(in_bus.frame_end),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_last    (out_bus.reply_last),
  .out_source  (out_bus.reply_source),
  .out_entry   (out_bus.matched_entry)
);

/* test/apdu_wildcard_table_responder_test.sv */
module apdu_wildcard_table_responder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import awtr_pkg::*;

  localparam int NE = DEF_TABLE_ENTRIES;
  localparam int NP = DEF_PATTERN_BYTES;
  localparam int NA = DEF_ANSWER_BYTES;
  localparam int NF = DEF_FRAME_BYTES;
  localparam int CYCLE_LIMIT = 400000;

  class reply_scoreboard;
    logic [7:0] frame_mem[NF];
    int         frame_cnt;
    logic [8:0] pat_mem[NE][NP];
    bit         pat_set[NE][NP];
    logic [7:0] ans_mem[NE][NA];
    bit         ans_set[NE][NA];
    int         pat_len[NE];
    int         ans_len[NE];
    logic [7:0] def_mem[NA];
    bit         def_set[NA];
    int         active_cnt;
    int         def_cnt;
    reply_t     pending[$];
    int         errors;

    function void set_reg(logic [1:0] idx, logic [7:0] d);
      if (idx == CFG_ACTIVE) active_cnt = d[4:0];
      else if (idx == CFG_DEFLEN) def_cnt = d[5:0];
    endfunction

    function logic [7:0] fbyte(int i);
      return (i < frame_cnt) ? frame_mem[i] : 8'h00;
    endfunction

    function bit entry_hits(int e, int off);
      int pos;
      logic [8:0] p;
      pos = 0;
      for (int j = 0; j < pat_len[e]; j++) begin
        p = pat_mem[e][j];
        if (off + pos + 2 >= frame_cnt) return 0;
        if (p[8]) begin
          if (fbyte(off + pos) != p[7:0]) return 0;
          pos++;
        end else if (p[7:0] == WILD_LEN) begin
          pos += 1 + fbyte(off + pos);
        end else begin
          pos++;
        end
      end
      return 1;
    endfunction

    function void build_reply();
      logic [7:0] bytes[$];
      logic [7:0] pcb;
      logic [1:0] src;
      int         ent, off, cnt;
      bit         found;
      reply_t     r;
      src = SRC_PLAIN;
      ent = 0;
      found = 0;
      pcb = fbyte(0);
      bytes.push_back(pcb);
      off = pcb[PCB_CID_BIT] ? 2 : 1;
      if (pcb[PCB_CID_BIT]) bytes.push_back(fbyte(1));
      cnt = (active_cnt > NE) ? NE : active_cnt;
      for (int e = 0; e < cnt && !found; e++) begin
        if (pat_len[e] != 0 && entry_hits(e, off)) begin
          for (int k = 0; k < ans_len[e]; k++) bytes.push_back(ans_mem[e][k]);
          src = SRC_TABLE;
          ent = e;
          found = 1;
        end
      end
      if (!found) begin
        if (def_cnt > 0) begin
          for (int k = 0; k < ((def_cnt > NA) ? NA : def_cnt); k++) bytes.push_back(def_mem[k]);
          src = SRC_DEF;
        end else begin
          bytes.push_back(SW1_OK);
          bytes.push_back(SW2_OK);
        end
      end
      foreach (bytes[k]) begin
        r.reply_byte    = bytes[k];
        r.reply_last    = (k == bytes.size() - 1);
        r.reply_source  = src;
        r.matched_entry = 4'(ent);
        pending.push_back(r);
      end
    endfunction

    function void note_accepted(in_item_t it);
      case (it.command)
        CMD_PAT: begin
          pat_mem[it.entry_slot][it.byte_position] = {it.exact_flag, it.byte_value};
          pat_set[it.entry_slot][it.byte_position] = 1;
        end
        CMD_ANS: begin
          if (it.byte_position < NA) begin
            ans_mem[it.entry_slot][it.byte_position] = it.byte_value;
            ans_set[it.entry_slot][it.byte_position] = 1;
          end
        end
        CMD_LEN: begin
          pat_len[it.entry_slot] = (it.pattern_length > NP) ? NP : it.pattern_length;
          ans_len[it.entry_slot] = (it.response_length > NA) ? NA : it.response_length;
        end
        CMD_DEF: begin
          if (it.byte_position < NA) begin
            def_mem[it.byte_position] = it.byte_value;
            def_set[it.byte_position] = 1;
          end
        end
        CMD_FRM: begin
          if (frame_cnt < NF) begin
            frame_mem[frame_cnt] = it.byte_value;
            frame_cnt++;
          end
          if (it.frame_end) begin
            build_reply();
            frame_cnt = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_reply(reply_t r);
      reply_t x;
      if (pending.size() == 0) begin
        report("unexpected reply byte", r.reply_byte, 0);
        return;
      end
      x = pending.pop_front();
      if (r.reply_byte !== x.reply_byte) report("reply_byte", r.reply_byte, x.reply_byte);
      if (r.reply_last !== x.reply_last) report("reply_last", r.reply_last, x.reply_last);
      if (r.reply_source !== x.reply_source)
        report("reply_source", r.reply_source, x.reply_source);
      if (r.matched_entry !== x.matched_entry)
        report("matched_entry", r.matched_entry, x.matched_entry);
    endtask

    function int pat_prefix(int e);
      int n;
      n = 0;
      while (n < NP && pat_set[e][n]) n++;
      return n;
    endfunction

    function int ans_prefix(int e);
      int n;
      n = 0;
      while (n < NA && ans_set[e][n]) n++;
      return n;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   snd_idle;
  int   rcv_idle;
  int   hold_left;
  int   sent;
  reply_scoreboard sb;

  awtr_in_if  in_bus();
  awtr_out_if out_bus();
  awtr_cfg_if cfg_bus();

  apdu_wildcard_table_responder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL apdu_wildcard_table_responder");
      $finish;
    end
  end

  // sample the reply channel before this edge's updates land
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        sb.check_reply('{out_bus.reply_byte, out_bus.reply_last, out_bus.reply_source,
                         out_bus.matched_entry});
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.command         <= it.command;
    in_bus.entry_slot      <= it.entry_slot;
    in_bus.byte_position   <= it.byte_position;
    in_bus.byte_value      <= it.byte_value;
    in_bus.exact_flag      <= it.exact_flag;
    in_bus.pattern_length  <= it.pattern_length;
    in_bus.response_length <= it.response_length;
    in_bus.frame_end       <= it.frame_end;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_accepted(it);
    sent++;
  endtask

  task automatic load(logic [2:0] cmd, int slot, int pos, int val, bit exact, int plen,
                      int rlen, bit fend);
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom});
    it.command = cmd;
    if (cmd == CMD_FRM) begin
      it.byte_value = 8'(val);
      it.frame_end  = fend;
    end else if (cmd <= CMD_DEF) begin
      it.entry_slot      = 4'(slot);
      it.byte_position   = 6'(pos);
      it.byte_value      = 8'(val);
      it.exact_flag      = exact;
      it.pattern_length  = 7'(plen);
      it.response_length = 6'(rlen);
    end
    send_item(it);
  endtask

  task automatic send_frame(logic [7:0] fr[$]);
    foreach (fr[k]) load(CMD_FRM, 0, 0, fr[k], 0, 0, 0, k == fr.size() - 1);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, d);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_entry(int e, int plen, int rlen, int rlen_field);
    int v;
    for (int j = 0; j < plen; j++) begin
      v = ($urandom_range(1)) ? WILD_LEN : $urandom_range(255);
      load(CMD_PAT, e, j, v, $urandom_range(99) < 55, 0, 0, 0);
    end
    for (int j = 0; j < rlen; j++) load(CMD_ANS, e, j, $urandom_range(255), 0, 0, 0, 0);
    load(CMD_LEN, e, 0, 0, 0, plen, rlen_field, 0);
  endtask

  // build a frame that walks the entry's pattern, optionally corrupted
  task automatic matching_frame(int e, output logic [7:0] fr[$]);
    logic [8:0] p;
    int         n;
    fr = {};
    fr.push_back({4'($urandom_range(15)), 1'($urandom_range(1)), 3'($urandom_range(7))});
    if (fr[0][PCB_CID_BIT]) fr.push_back(8'($urandom_range(255)));
    for (int j = 0; j < sb.pat_len[e]; j++) begin
      p = sb.pat_mem[e][j];
      if (p[8]) begin
        fr.push_back(p[7:0]);
      end else if (p[7:0] == WILD_LEN) begin
        n = $urandom_range(3);
        fr.push_back(8'(n));
        repeat (n) fr.push_back(8'($urandom_range(255)));
      end else begin
        fr.push_back(8'($urandom_range(255)));
      end
    end
    repeat ($urandom_range(2)) fr.push_back(8'($urandom_range(255)));
    repeat (2) fr.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 25) fr[$urandom_range(fr.size() - 1)] = 8'($urandom_range(255));
  endtask

  task automatic random_mix(int count);
    logic [7:0] fr[$];
    int         stop, r, e, pl, rl, tries;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 22) begin
        e = $urandom_range(NE - 1);
        rl = $urandom_range(5);
        program_entry(e, $urandom_range(1, 6), rl, rl);
      end else if (r < 70) begin
        e = $urandom_range(NE - 1);
        tries = 0;
        while (sb.pat_len[e] == 0 && tries < 16) begin
          e = (e + 1) % NE;
          tries++;
        end
        matching_frame(e, fr);
        send_frame(fr);
      end else if (r < 80) begin
        fr = {};
        repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom_range(255)));
        send_frame(fr);
      end else if (r < 85) begin
        load(3'($urandom_range(5, 7)), 0, 0, 0, 0, 0, 0, 0);
      end else if (r < 89) begin
        load(CMD_ANS, $urandom_range(NE - 1), $urandom_range(NA, 63), $urandom_range(255),
             0, 0, 0, 0);
      end else if (r < 93) begin
        load(CMD_DEF, 0, $urandom_range(63), $urandom_range(255), 0, 0, 0, 0);
      end else begin
        // disable or reshape an entry within what has been written
        e  = $urandom_range(NE - 1);
        pl = $urandom_range(1) ? 0 : $urandom_range(sb.pat_prefix(e));
        rl = $urandom_range(sb.ans_prefix(e));
        load(CMD_LEN, e, 0, 0, 0, pl, rl, 0);
      end
    end
  endtask

  initial begin
    logic [7:0] fr[$];
    sb = new();
    cycles = 0;
    sent = 0;
    hold_left = 0;
    snd_idle = 13;
    rcv_idle = 60;
    rst_n = 1'b0;
    in_bus.valid <= 1'b0;
    {in_bus.command, in_bus.entry_slot, in_bus.byte_position, in_bus.byte_value,
     in_bus.exact_flag, in_bus.pattern_length, in_bus.response_length,
     in_bus.frame_end} <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_ACTIVE, 8'd31);
    write_reg(CFG_DEFLEN, 8'd0);

    // entry 0: exact A4, length skip, exact FF
    load(CMD_PAT, 0, 0, 8'hA4, 1, 0, 0, 0);
    load(CMD_PAT, 0, 1, WILD_LEN, 0, 0, 0, 0);
    load(CMD_PAT, 0, 2, 8'hFF, 1, 0, 0, 0);
    load(CMD_ANS, 0, 0, 8'h00, 0, 0, 0, 0);
    load(CMD_ANS, 0, 1, 8'hFF, 0, 0, 0, 0);
    load(CMD_LEN, 0, 0, 0, 0, 3, 2, 0);
    send_frame('{8'h02, 8'hA4, 8'h02, 8'h11, 8'h22, 8'hFF, 8'h55, 8'hAA});
    send_frame('{8'h0A, 8'hFF, 8'hA4, 8'h00, 8'hFF, 8'h00, 8'h00});
    send_frame('{8'h02, 8'hA4, 8'h00, 8'hFF, 8'h00});
    send_frame('{8'h08});
    send_frame('{8'hFF});
    load(3'd7, 0, 0, 0, 0, 0, 0, 0);
    random_mix(16);

    wait_idle();
    for (int k = 0; k < NA; k++) load(CMD_DEF, 0, k, $urandom_range(255), 0, 0, 0, 0);
    wait_idle();
    write_reg(CFG_ACTIVE, 8'd5);
    write_reg(CFG_DEFLEN, 8'd63);
    snd_idle = 60;
    rcv_idle = 13;
    random_mix(16);

    wait_idle();
    write_reg(CFG_ACTIVE, 8'd16);
    write_reg(CFG_DEFLEN, 8'd32);
    snd_idle = 0;
    rcv_idle = 0;
    // full-size response with an oversized length field
    program_entry(15, 6, NA, 63);
    for (int k = 0; k < NE - 1; k++) load(CMD_LEN, k, 0, 0, 0, 0, 0, 0);
    hold_left = 300;
    repeat (2) begin
      matching_frame(15, fr);
      send_frame(fr);
    end
    fr = {};
    repeat (NF + 4) fr.push_back(8'($urandom_range(255)));
    send_frame(fr);
    random_mix(6);

    wait_idle();
    write_reg(CFG_ACTIVE, 8'd0);
    write_reg(CFG_DEFLEN, 8'd1);
    random_mix(6);

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS apdu_wildcard_table_responder");
    end else begin
      $display("FAIL apdu_wildcard_table_responder");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/awtr_pkg.sv
rtl/core/awtr_if.sv
rtl/core/awtr_obuf.sv
rtl/core/awtr_engine.sv
rtl/core/apdu_wildcard_table_responder.sv
rtl/core/awtr_checker.sv
test/apdu_wildcard_table_responder_test.sv
